/* design/gce_pkg.sv */
// Shared constants and types for the grid clearance erosion block.
package gce_pkg;

  localparam int GRID_W = 1024;
  localparam int GRID_H = 1024;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 10;
  localparam int DIM_W  = 11;
  localparam int HALF_W = 5;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_WIDTH_IN_USE  = 3'd0;
  localparam logic [2:0] REG_HEIGHT_IN_USE = 3'd1;
  localparam logic [2:0] REG_HALF_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HALF_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_IS_FLYER      = 3'd4;
  localparam logic [2:0] REG_IS_FLYING     = 3'd5;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_FIXED = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]  width_eff;
    logic [DIM_W-1:0]  height_eff;
    logic [HALF_W-1:0] half_width;
    logic [HALF_W-1:0] half_height;
    logic              is_flyer;
    logic              is_flying;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ROW_W-1:0] y0;
    logic [ROW_W-1:0] y1;
    logic [COL_W-1:0] x0;
    logic [COL_W-1:0] x1;
    logic             bit_val;
    logic             outside;
  } cmd_t;

endpackage

/* design/grid_clearance_erosion_top.sv */
// Top level of the grid clearance erosion block.
// A load follows a load every cycle while no window scan holds the back end.
// Window queries scan one bitmap row per cycle through the row-wide RAM read port;
// a query covers 1 to 63 rows and holds the back end until its last row is checked.
// Outside-grid and flyer queries answer without a row scan.
// Synchronous reset restores register defaults and empties the queue; the bitmap is unset.
module grid_clearance_erosion_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_mode,
  input  logic [gce_pkg::COL_W-1:0]  in_column,
  input  logic [gce_pkg::ROW_W-1:0]  in_row,
  input  logic                       in_terrain_walkable,
  output logic                       out_valid,
  output logic                       out_clear_to_stand,
  output logic                       out_outside_grid,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gce_pkg::ADDR_W-1:0] paddr,
  input  logic [gce_pkg::DATA_W-1:0] pwdata,
  output logic [gce_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  gce_pkg::cfg_t cfg;
  gce_pkg::cmd_t push_cmd, head;
  logic          push, pop, empty, full;

  assign busy = full;

  gce_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  gce_front u_front (
    .accept          (start & ~busy),
    .mode            (in_mode),
    .column          (in_column),
    .row             (in_row),
    .terrain_walkable(in_terrain_walkable),
    .cfg             (cfg),
    .push            (push),
    .cmd             (push_cmd)
  );

  gce_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  gce_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .empty             (empty),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_clear_to_stand(out_clear_to_stand),
    .out_outside_grid  (out_outside_grid)
  );

endmodule

/* design/gce_ram.sv */
// Generic single write port RAM with bit write mask and registered read.
module gce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [WIDTH-1:0]         wmask,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/gce_regs.sv */
// Configuration registers behind the APB-style port.
module gce_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gce_pkg::ADDR_W-1:0] paddr,
  input  logic [gce_pkg::DATA_W-1:0] pwdata,
  output logic [gce_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output gce_pkg::cfg_t              cfg
);

  logic [gce_pkg::DIM_W-1:0]  width_r, height_r;
  logic [gce_pkg::HALF_W-1:0] half_w_r, half_h_r;
  logic                       flyer_r, flying_r;
  logic [2:0]                 idx;
  logic                       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gce_pkg::DIM_W'(gce_pkg::GRID_W);
      height_r <= gce_pkg::DIM_W'(gce_pkg::GRID_H);
      half_w_r <= gce_pkg::HALF_W'(1);
      half_h_r <= gce_pkg::HALF_W'(1);
      flyer_r  <= 1'b0;
      flying_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        gce_pkg::REG_WIDTH_IN_USE:  width_r  <= pwdata[gce_pkg::DIM_W-1:0];
        gce_pkg::REG_HEIGHT_IN_USE: height_r <= pwdata[gce_pkg::DIM_W-1:0];
        gce_pkg::REG_HALF_WIDTH:    half_w_r <= pwdata[gce_pkg::HALF_W-1:0];
        gce_pkg::REG_HALF_HEIGHT:   half_h_r <= pwdata[gce_pkg::HALF_W-1:0];
        gce_pkg::REG_IS_FLYER:      flyer_r  <= pwdata[0];
        gce_pkg::REG_IS_FLYING:     flying_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gce_pkg::REG_WIDTH_IN_USE:  prdata = gce_pkg::DATA_W'(width_r);
      gce_pkg::REG_HEIGHT_IN_USE: prdata = gce_pkg::DATA_W'(height_r);
      gce_pkg::REG_HALF_WIDTH:    prdata = gce_pkg::DATA_W'(half_w_r);
      gce_pkg::REG_HALF_HEIGHT:   prdata = gce_pkg::DATA_W'(half_h_r);
      gce_pkg::REG_IS_FLYER:      prdata = gce_pkg::DATA_W'(flyer_r);
      gce_pkg::REG_IS_FLYING:     prdata = gce_pkg::DATA_W'(flying_r);
      default:                    prdata = '0;
    endcase
  end

  always_comb begin
    cfg.width_eff   = (width_r > gce_pkg::DIM_W'(gce_pkg::GRID_W)) ?
                      gce_pkg::DIM_W'(gce_pkg::GRID_W) : width_r;
    cfg.height_eff  = (height_r > gce_pkg::DIM_W'(gce_pkg::GRID_H)) ?
                      gce_pkg::DIM_W'(gce_pkg::GRID_H) : height_r;
    cfg.half_width  = half_w_r;
    cfg.half_height = half_h_r;
    cfg.is_flyer    = flyer_r;
    cfg.is_flying   = flying_r;
  end

endmodule

/* design/gce_front.sv */
// Front end: classify each accepted item into a command for the back end.
module gce_front (
  input  logic                      accept,
  input  logic                      mode,
  input  logic [gce_pkg::COL_W-1:0] column,
  input  logic [gce_pkg::ROW_W-1:0] row,
  input  logic                      terrain_walkable,
  input  gce_pkg::cfg_t             cfg,
  output logic                      push,
  output gce_pkg::cmd_t             cmd
);

  logic                      in_grid;
  logic [gce_pkg::DIM_W-1:0] col_hi, row_hi;
  logic [gce_pkg::DIM_W-1:0] w_last, h_last;
  logic [gce_pkg::COL_W-1:0] x0, x1;
  logic [gce_pkg::ROW_W-1:0] y0, y1;

  assign in_grid = ({1'b0, column} < cfg.width_eff) && ({1'b0, row} < cfg.height_eff);
  assign col_hi = {1'b0, column} + gce_pkg::DIM_W'(cfg.half_width);
  assign row_hi = {1'b0, row} + gce_pkg::DIM_W'(cfg.half_height);
  assign w_last = cfg.width_eff - gce_pkg::DIM_W'(1);
  assign h_last = cfg.height_eff - gce_pkg::DIM_W'(1);

  always_comb begin
    x0 = (column > gce_pkg::COL_W'(cfg.half_width)) ?
         column - gce_pkg::COL_W'(cfg.half_width) : '0;
    y0 = (row > gce_pkg::ROW_W'(cfg.half_height)) ?
         row - gce_pkg::ROW_W'(cfg.half_height) : '0;
    x1 = (col_hi > w_last) ? w_last[gce_pkg::COL_W-1:0] : col_hi[gce_pkg::COL_W-1:0];
    y1 = (row_hi > h_last) ? h_last[gce_pkg::ROW_W-1:0] : row_hi[gce_pkg::ROW_W-1:0];
    if (cfg.is_flying) begin
      x0 = column;
      x1 = column;
      y0 = row;
      y1 = row;
    end
  end

  always_comb begin
    push        = 1'b0;
    cmd.kind    = gce_pkg::CMD_FIXED;
    cmd.y0      = row;
    cmd.y1      = y1;
    cmd.x0      = column;
    cmd.x1      = x1;
    cmd.bit_val = 1'b0;
    cmd.outside = 1'b0;
    if (accept) begin
      if (!mode) begin
        push        = in_grid;
        cmd.kind    = gce_pkg::CMD_LOAD;
        cmd.bit_val = terrain_walkable;
      end else if (!in_grid) begin
        push        = 1'b1;
        cmd.outside = 1'b1;
      end else if (cfg.is_flyer) begin
        push        = 1'b1;
        cmd.bit_val = 1'b1;
      end else begin
        push     = 1'b1;
        cmd.kind = gce_pkg::CMD_SCAN;
        cmd.y0   = y0;
        cmd.x0   = x0;
      end
    end
  end

endmodule

/* design/gce_queue.sv */
// Two-entry command queue between front and back end.
module gce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gce_pkg::cmd_t push_cmd,
  input  logic          pop,
  output gce_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);

  gce_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/gce_back.sv */
// Back end: bitmap writes, window row scans and result output.
module gce_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  gce_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  output logic          out_clear_to_stand,
  output logic          out_outside_grid
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                         state_r, state_nxt;
  logic [gce_pkg::ROW_W-1:0]    y_r, y_nxt, y1_r, y1_nxt;
  logic [gce_pkg::GRID_W-1:0]   mask_r, mask_nxt;
  logic                         ok_r, ok_nxt;
  logic                         valid_r, valid_nxt;
  logic                         clear_r, clear_nxt;
  logic                         outside_r, outside_nxt;
  logic                         we;
  logic [gce_pkg::ROW_W-1:0]    raddr;
  logic [gce_pkg::GRID_W-1:0]   rdata, wdata, wmask;
  logic                         row_ok;

  assign pop    = (state_r == ST_IDLE) && !empty;
  assign we     = pop && (head.kind == gce_pkg::CMD_LOAD);
  assign wdata  = {gce_pkg::GRID_W{head.bit_val}};
  assign wmask  = {{(gce_pkg::GRID_W-1){1'b0}}, 1'b1} << head.x0;
  assign raddr  = (state_r == ST_IDLE) ? head.y0 : y_r + gce_pkg::ROW_W'(1);
  assign row_ok = &(rdata | ~mask_r);

  gce_ram #(
    .WIDTH(gce_pkg::GRID_W),
    .DEPTH(gce_pkg::GRID_H)
  ) u_bitmap (
    .clk  (clk),
    .we   (we),
    .waddr(head.y0),
    .wdata(wdata),
    .wmask(wmask),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    y_nxt       = y_r;
    y1_nxt      = y1_r;
    mask_nxt    = mask_r;
    ok_nxt      = ok_r;
    valid_nxt   = 1'b0;
    clear_nxt   = clear_r;
    outside_nxt = outside_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head.kind)
            gce_pkg::CMD_SCAN: begin
              state_nxt = ST_SCAN;
              y_nxt     = head.y0;
              y1_nxt    = head.y1;
              ok_nxt    = 1'b1;
              mask_nxt  = ({gce_pkg::GRID_W{1'b1}} << head.x0) &
                          ({gce_pkg::GRID_W{1'b1}} >>
                           (gce_pkg::COL_W'(gce_pkg::GRID_W - 1) - head.x1));
            end
            gce_pkg::CMD_FIXED: begin
              valid_nxt   = 1'b1;
              clear_nxt   = head.bit_val;
              outside_nxt = head.outside;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ok_nxt = ok_r & row_ok;
        if (y_r == y1_r) begin
          state_nxt   = ST_IDLE;
          valid_nxt   = 1'b1;
          clear_nxt   = ok_r & row_ok;
          outside_nxt = 1'b0;
        end else begin
          y_nxt = y_r + gce_pkg::ROW_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    y_r       <= y_nxt;
    y1_r      <= y1_nxt;
    mask_r    <= mask_nxt;
    ok_r      <= ok_nxt;
    clear_r   <= clear_nxt;
    outside_r <= outside_nxt;
  end

  assign out_valid          = valid_r;
  assign out_clear_to_stand = clear_r;
  assign out_outside_grid   = outside_r;

endmodule

/* tb/sv/grid_clearance_erosion_top_test.sv */
// Self-checking testbench for the grid clearance erosion block: terrain loads, clearance queries.
module grid_clearance_erosion_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gce_pkg::*;

  localparam bit         MODE_LOAD     = 1'b0;
  localparam bit         MODE_QUERY    = 1'b1;
  localparam logic [2:0] REG_SPARE     = 3'd7;
  localparam int         ITEM_TARGET   = 650;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         RUN_LIMIT_NS  = 2_000_000;
  localparam int         REPORT_CAP    = 40;

  typedef struct packed {
    logic clear_to_stand;
    logic outside_grid;
  } stand_t;

  typedef struct packed {
    bit          reg_write;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    bit          mode;
    logic [9:0]  col;
    logic [9:0]  row;
    bit          walk;
    bit          typed;
    stand_t      want;
  } step_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic              in_terrain_walkable;
  logic              out_valid;
  logic              out_clear_to_stand;
  logic              out_outside_grid;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit terrain_map [0:GRID_W*GRID_H-1];
  bit loaded_map  [0:GRID_W*GRID_H-1];

  logic [DIM_W-1:0]  cols_cfg;
  logic [DIM_W-1:0]  rows_cfg;
  logic [HALF_W-1:0] reach_x;
  logic [HALF_W-1:0] reach_y;
  logic              flyer_cfg;
  logic              airborne_cfg;

  stand_t stand_q[$];
  step_t  script[$];
  int     fault_count = 0;
  int     items_done  = 0;
  bit     settled     = 1'b1;
  bit     no_gaps     = 1'b0;

  grid_clearance_erosion_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_terrain_walkable (in_terrain_walkable),
    .out_valid           (out_valid),
    .out_clear_to_stand  (out_clear_to_stand),
    .out_outside_grid    (out_outside_grid),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #2 clk = ~clk;

  function automatic int eff_cols();
    return (cols_cfg > GRID_W) ? GRID_W : int'(cols_cfg);
  endfunction

  function automatic int eff_rows();
    return (rows_cfg > GRID_H) ? GRID_H : int'(rows_cfg);
  endfunction

  // {every cell walkable, every cell loaded} over the clipped clearance window
  function automatic bit [1:0] scan_window(input int col, input int row);
    int x0, x1, y0, y1, x, y;
    bit open_all, loaded_all;
    x0 = (col > reach_x) ? col - reach_x : 0;
    y0 = (row > reach_y) ? row - reach_y : 0;
    x1 = col + reach_x;
    y1 = row + reach_y;
    if (x1 > eff_cols() - 1) x1 = eff_cols() - 1;
    if (y1 > eff_rows() - 1) y1 = eff_rows() - 1;
    open_all   = 1'b1;
    loaded_all = 1'b1;
    for (y = y0; y <= y1; y++) begin
      for (x = x0; x <= x1; x++) begin
        open_all   &= terrain_map[y*GRID_W + x];
        loaded_all &= loaded_map[y*GRID_W + x];
      end
    end
    return {open_all, loaded_all};
  endfunction

  function automatic bit query_safe(input int col, input int row);
    bit [1:0] win;
    if (col >= eff_cols() || row >= eff_rows() || flyer_cfg) return 1'b1;
    win = scan_window(col, row);
    return win[0];
  endfunction

  function automatic stand_t predict_stand(input int col, input int row);
    stand_t   s;
    bit [1:0] win;
    s = 2'b00;
    if (col >= eff_cols() || row >= eff_rows()) s.outside_grid = 1'b1;
    else if (flyer_cfg) s.clear_to_stand = 1'b1;
    else if (!terrain_map[row*GRID_W + col]) s.clear_to_stand = 1'b0;
    else if (airborne_cfg) s.clear_to_stand = 1'b1;
    else begin
      win = scan_window(col, row);
      s.clear_to_stand = win[1];
    end
    return s;
  endfunction

  task automatic report(input string what, input logic want_v, input logic got_v);
    fault_count++;
    if (fault_count <= REPORT_CAP)
      $display("%0t: %s mismatch: expected %b, actual %b", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch_results
    stand_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (stand_q.size() == 0) begin
        report("unexpected result, clear_to_stand", 1'bx, out_clear_to_stand);
      end else begin
        want = stand_q.pop_front();
        if (out_clear_to_stand !== want.clear_to_stand)
          report("clear_to_stand", want.clear_to_stand, out_clear_to_stand);
        if (out_outside_grid !== want.outside_grid)
          report("outside_grid", want.outside_grid, out_outside_grid);
      end
    end
  end

  task automatic send_item(input bit mode, input int col, input int row, input bit walk,
                           input bit typed, input stand_t want);
    int     gap, roll;
    bit     in_grid;
    stand_t exp_s;
    if (no_gaps) gap = 0;
    else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               = 1'b1;
    in_mode             = mode;
    in_column           = col[COL_W-1:0];
    in_row              = row[ROW_W-1:0];
    in_terrain_walkable = walk;
    do @(posedge clk); while (busy !== 1'b0);
    settled = 1'b0;
    in_grid = (col < eff_cols()) && (row < eff_rows());
    if (mode == MODE_LOAD) begin
      if (in_grid) begin
        terrain_map[row*GRID_W + col] = walk;
        loaded_map[row*GRID_W + col]  = 1'b1;
        items_done++;
      end
    end else begin
      exp_s   = typed ? want : predict_stand(col, row);
      stand_q = {stand_q, exp_s};
      items_done++;
    end
  endtask

  // drop start, drain every pending result, then let queued loads retire
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (stand_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settled = 1'b1;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    if (!settled) settle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_WIDTH_IN_USE:  cols_cfg     = val[DIM_W-1:0];
      REG_HEIGHT_IN_USE: rows_cfg     = val[DIM_W-1:0];
      REG_HALF_WIDTH:    reach_x      = val[HALF_W-1:0];
      REG_HALF_HEIGHT:   reach_y      = val[HALF_W-1:0];
      REG_IS_FLYER:      flyer_cfg    = val[0];
      REG_IS_FLYING:     airborne_cfg = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic add_reg(input logic [2:0] idx, input logic [31:0] val);
    step_t s;
    s           = '0;
    s.reg_write = 1'b1;
    s.reg_idx   = idx;
    s.reg_val   = val;
    script      = {script, s};
  endtask

  task automatic add_load(input int col, input int row, input bit walk);
    step_t s;
    s      = '0;
    s.mode = MODE_LOAD;
    s.col  = col[9:0];
    s.row  = row[9:0];
    s.walk = walk;
    script = {script, s};
  endtask

  task automatic add_check(input int col, input int row, input bit clear, input bit outside);
    step_t s;
    s       = '0;
    s.mode  = MODE_QUERY;
    s.col   = col[9:0];
    s.row   = row[9:0];
    s.typed = 1'b1;
    s.want  = {clear, outside};
    script  = {script, s};
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : run
    int    col, row, px0, py0, pw, ph, blk_odds, n_query, sel, tries;
    bit    tight;
    step_t s;

    rst_n               = 1'b0;
    start               = 1'b0;
    in_mode             = MODE_LOAD;
    in_column           = '0;
    in_row              = '0;
    in_terrain_walkable = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cols_cfg            = DIM_W'(GRID_W);
    rows_cfg            = DIM_W'(GRID_H);
    reach_x             = HALF_W'(1);
    reach_y             = HALF_W'(1);
    flyer_cfg           = 1'b0;
    airborne_cfg        = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_load(0, 0, 1'b1);
    add_load(1, 0, 1'b1);
    add_load(0, 1, 1'b1);
    add_load(1, 1, 1'b1);
    add_check(0, 0, 1'b1, 1'b0);
    add_load(1, 1, 1'b0);
    add_check(0, 0, 1'b0, 1'b0);
    add_load(1022, 1022, 1'b1);
    add_load(1023, 1022, 1'b1);
    add_load(1022, 1023, 1'b1);
    add_load(1023, 1023, 1'b1);
    add_check(1023, 1023, 1'b1, 1'b0);
    add_load(1023, 1023, 1'b0);
    add_check(1023, 1023, 1'b0, 1'b0);
    add_reg(REG_WIDTH_IN_USE, 2);
    add_reg(REG_HEIGHT_IN_USE, 2);
    add_check(2, 0, 1'b0, 1'b1);
    add_check(0, 1023, 1'b0, 1'b1);
    add_load(5, 5, 1'b1);
    add_reg(REG_IS_FLYER, 1);
    add_check(1, 1, 1'b1, 1'b0);
    add_check(1023, 0, 1'b0, 1'b1);
    add_reg(REG_IS_FLYER, 0);
    add_reg(REG_IS_FLYING, 1);
    add_check(0, 0, 1'b1, 1'b0);
    add_check(1, 1, 1'b0, 1'b0);
    add_reg(REG_IS_FLYING, 0);
    add_reg(REG_HALF_WIDTH, 31);
    add_reg(REG_HALF_HEIGHT, 31);
    add_check(0, 1, 1'b0, 1'b0);
    add_reg(REG_WIDTH_IN_USE, 0);
    add_check(0, 0, 1'b0, 1'b1);
    add_reg(REG_WIDTH_IN_USE, 2047);
    add_reg(REG_HEIGHT_IN_USE, 2047);
    add_reg(REG_HALF_WIDTH, 0);
    add_reg(REG_HALF_HEIGHT, 0);
    add_check(0, 0, 1'b1, 1'b0);
    add_check(1023, 1023, 1'b0, 1'b0);
    add_reg(REG_HALF_HEIGHT, 1);
    add_check(0, 0, 1'b1, 1'b0);
    add_reg(REG_SPARE, 32'hFFFF_FFFF);
    add_check(1, 0, 1'b0, 1'b0);

    foreach (script[i]) begin
      s = script[i];
      if (s.reg_write) write_reg(s.reg_idx, s.reg_val);
      else send_item(s.mode, s.col, s.row, s.walk, s.typed, s.want);
    end

    while (items_done < ITEM_TARGET) begin
      tight   = ($urandom_range(0, 3) == 0);
      no_gaps = ($urandom_range(0, 4) == 0);
      if (tight) begin
        write_reg(REG_WIDTH_IN_USE, $urandom_range(0, 8));
        write_reg(REG_HEIGHT_IN_USE, $urandom_range(0, 8));
        write_reg(REG_HALF_WIDTH, $urandom_range(0, 31));
        write_reg(REG_HALF_HEIGHT, $urandom_range(0, 31));
        px0 = 0;
        py0 = 0;
        pw  = eff_cols();
        ph  = eff_rows();
      end else begin
        write_reg(REG_WIDTH_IN_USE, $urandom_range(0, 1) ? GRID_W : $urandom_range(1, 2047));
        write_reg(REG_HEIGHT_IN_USE, $urandom_range(0, 1) ? GRID_H : $urandom_range(1, 2047));
        write_reg(REG_HALF_WIDTH,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2));
        write_reg(REG_HALF_HEIGHT,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2));
        pw = 2*reach_x + 1 + $urandom_range(0, 4);
        ph = 2*reach_y + 1 + $urandom_range(0, 4);
        if (pw > eff_cols()) pw = eff_cols();
        if (ph > eff_rows()) ph = eff_rows();
        px0 = $urandom_range(0, eff_cols() - pw);
        py0 = $urandom_range(0, eff_rows() - ph);
      end
      write_reg(REG_IS_FLYER, 32'($urandom_range(0, 5) == 0));
      write_reg(REG_IS_FLYING, 32'($urandom_range(0, 5) == 0));

      blk_odds = $urandom_range(3, 40);
      for (row = py0; row < py0 + ph; row++)
        for (col = px0; col < px0 + pw; col++)
          send_item(MODE_LOAD, col, row, $urandom_range(1, blk_odds) != 1, 1'b0, 2'b00);

      n_query = $urandom_range(15, 40);
      repeat (n_query) begin
        sel = $urandom_range(0, 19);
        if (sel < 16 && pw > 0 && ph > 0) begin
          col = px0 + $urandom_range(0, pw - 1);
          row = py0 + $urandom_range(0, ph - 1);
        end else begin
          col = $urandom_range(0, 1023);
          row = $urandom_range(0, 1023);
        end
        if (sel < 13 || sel >= 18) begin
          tries = 0;
          while (!query_safe(col, row) && tries < 20 && sel < 13 && pw > 0 && ph > 0) begin
            col = px0 + $urandom_range(0, pw - 1);
            row = py0 + $urandom_range(0, ph - 1);
            tries++;
          end
          if (query_safe(col, row)) send_item(MODE_QUERY, col, row, 1'($urandom_range(0, 1)),
                                              1'b0, 2'b00);
          else send_item(MODE_LOAD, col, row, $urandom_range(1, blk_odds) != 1, 1'b0, 2'b00);
        end else begin
          send_item(MODE_LOAD, col, row, 1'($urandom_range(0, 1)), 1'b0, 2'b00);
        end
      end
    end

    settle();
    if (fault_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
